// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/stok_pkg.sv =====
// Types, token codes, character constants and classifiers for the tokenizer.
`timescale 1ns / 1ps

package stok_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 16;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Token kinds
  localparam logic [5:0] K_NONE     = 6'd0;  // no match from a classifier
  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_NUMBER   = 6'd2;
  localparam logic [5:0] K_STRING   = 6'd3;
  localparam logic [5:0] K_CARET    = 6'd4;
  localparam logic [5:0] K_AMP      = 6'd5;
  localparam logic [5:0] K_STAR     = 6'd6;
  localparam logic [5:0] K_PLUS     = 6'd7;
  localparam logic [5:0] K_INC      = 6'd8;
  localparam logic [5:0] K_PLUS_EQ  = 6'd9;
  localparam logic [5:0] K_MINUS    = 6'd10;
  localparam logic [5:0] K_DEC      = 6'd11;
  localparam logic [5:0] K_MINUS_EQ = 6'd12;
  localparam logic [5:0] K_ASSIGN   = 6'd13;
  localparam logic [5:0] K_EQ       = 6'd14;
  localparam logic [5:0] K_COLON    = 6'd15;
  localparam logic [5:0] K_SEMI     = 6'd16;
  localparam logic [5:0] K_DOT      = 6'd17;
  localparam logic [5:0] K_COMMA    = 6'd18;
  localparam logic [5:0] K_SLASH    = 6'd19;
  localparam logic [5:0] K_LPAREN   = 6'd20;
  localparam logic [5:0] K_RPAREN   = 6'd21;
  localparam logic [5:0] K_LBRACK   = 6'd22;
  localparam logic [5:0] K_RBRACK   = 6'd23;
  localparam logic [5:0] K_LBRACE   = 6'd24;
  localparam logic [5:0] K_RBRACE   = 6'd25;
  localparam logic [5:0] K_LT       = 6'd26;
  localparam logic [5:0] K_LE       = 6'd27;
  localparam logic [5:0] K_GT       = 6'd28;
  localparam logic [5:0] K_GE       = 6'd29;
  localparam logic [5:0] K_BANG     = 6'd30;
  localparam logic [5:0] K_NE       = 6'd31;
  localparam logic [5:0] K_ERROR    = 6'd32;

  // Characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_source;
  } tok_in_t;

  typedef struct packed {
    logic [5:0]             token_kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] start_line;
    logic [LENGTH_BITS-1:0] start_column;
    logic [LENGTH_BITS-1:0] token_length;
    logic [7:0]             bad_byte;
    logic                   last_of_run;
  } tok_out_t;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_held_op(logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_EQUAL || b == CH_LT ||
           b == CH_GT || b == CH_BANG;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] b);
    logic [5:0] k;
    case (b)
      CH_CARET:  k = K_CARET;
      CH_AMP:    k = K_AMP;
      CH_STAR:   k = K_STAR;
      CH_COLON:  k = K_COLON;
      CH_SEMI:   k = K_SEMI;
      CH_DOT:    k = K_DOT;
      CH_COMMA:  k = K_COMMA;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      default:   k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] held_single_kind(logic [7:0] h);
    logic [5:0] k;
    case (h)
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_EQUAL: k = K_ASSIGN;
      CH_LT:    k = K_LT;
      CH_GT:    k = K_GT;
      default:  k = K_BANG;
    endcase
    return k;
  endfunction

  // Kind of the two-byte operator h,b, or K_NONE when they do not pair.
  function automatic logic [5:0] pair_kind(logic [7:0] h, logic [7:0] b);
    logic [5:0] k;
    k = K_NONE;
    if (b == CH_EQUAL) begin
      case (h)
        CH_PLUS:  k = K_PLUS_EQ;
        CH_MINUS: k = K_MINUS_EQ;
        CH_EQUAL: k = K_EQ;
        CH_LT:    k = K_LE;
        CH_GT:    k = K_GE;
        CH_BANG:  k = K_NE;
        default:  k = K_NONE;
      endcase
    end else if (h == CH_PLUS && b == CH_PLUS) begin
      k = K_INC;
    end else if (h == CH_MINUS && b == CH_MINUS) begin
      k = K_DEC;
    end
    return k;
  endfunction

  function automatic tok_out_t make_tok(logic [5:0] kind,
                                        logic [OFFSET_BITS-1:0] off,
                                        logic [OFFSET_BITS-1:0] line,
                                        logic [LENGTH_BITS-1:0] col,
                                        logic [LENGTH_BITS-1:0] len,
                                        logic [7:0] bad);
    tok_out_t t;
    t.token_kind   = kind;
    t.start_offset = off;
    t.start_line   = line;
    t.start_column = col;
    t.token_length = len;
    t.bad_byte     = bad;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_inc(logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/source_tokenizer_core.sv =====
// Streaming tokenizer: one source byte per request in, tokens out through a small queue.
`timescale 1ns / 1ps

//  channel  | signals                          | request carries
//  ---------+----------------------------------+-----------------------------------------
//  src      | src_valid, src_ready, src_data   | one byte, has-byte flag, end-of-source
//  tok      | tok_valid, tok_ready, tok_data   | one token: kind, position, length, ...
//
//  One src request is taken per cycle as long as at least three token queue slots are
//  free; the scanner state updates in the same cycle. A request makes 0 to 3 tokens,
//  written into a 4-entry queue; tok drains one token per cycle while tok_ready is high,
//  so a stream where each byte closes at most one token runs at 1 byte/cycle unless tok
//  stalls; a byte that yields more tokens holds src off. tok_data comes straight from
//  queue registers. rst (synchronous) clears scanner state, positions and the queue.
//  Stalling tok only fills the queue; src_ready drops once fewer than three slots remain.

`include "assert_macros.svh"

module source_tokenizer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  stok_pkg::tok_in_t  src_data,
  output logic              tok_valid,
  input  logic              tok_ready,
  output stok_pkg::tok_out_t tok_data
);

  localparam int OB     = stok_pkg::OFFSET_BITS;
  localparam int LB     = stok_pkg::LENGTH_BITS;
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam int MAXRES = 3;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_HELD, M_SLASH, M_COMMENT, M_ERROR
  } mode_t;

  // Scanner state
  mode_t          scan_mode;
  logic [7:0]     held_byte;
  logic [OB-1:0]  cur_offset;
  logic [OB-1:0]  cur_line;
  logic [LB-1:0]  cur_column;
  logic [OB-1:0]  tok_start_offset;
  logic [OB-1:0]  tok_start_line;
  logic [LB-1:0]  tok_start_column;
  logic [LB-1:0]  tok_len;

  mode_t          scan_mode_next;
  logic [7:0]     held_byte_next;
  logic [OB-1:0]  cur_offset_next;
  logic [OB-1:0]  cur_line_next;
  logic [LB-1:0]  cur_column_next;
  logic [OB-1:0]  tok_start_offset_next;
  logic [OB-1:0]  tok_start_line_next;
  logic [LB-1:0]  tok_start_column_next;
  logic [LB-1:0]  tok_len_next;

  // Tokens produced by the current request
  stok_pkg::tok_out_t res [MAXRES];
  logic [1:0]         res_count;

  // Token queue
  stok_pkg::tok_out_t queue [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  logic src_fire;
  logic tok_fire;

  assign src_ready = (count <= CNT_W'(QDEPTH - MAXRES));
  assign src_fire  = src_valid && src_ready;
  assign tok_valid = (count != '0);
  assign tok_fire  = tok_valid && tok_ready;
  assign tok_data  = queue[rd_ptr];

  // Single-pass scanner: mirrors the byte-level state machine, then the end flush.
  always_comb begin
    logic [7:0] b;
    logic       do_start;
    logic [5:0] k;

    b        = src_data.char_byte;
    do_start = 1'b0;
    k        = stok_pkg::K_NONE;

    scan_mode_next        = scan_mode;
    held_byte_next        = held_byte;
    cur_offset_next       = cur_offset;
    cur_line_next         = cur_line;
    cur_column_next       = cur_column;
    tok_start_offset_next = tok_start_offset;
    tok_start_line_next   = tok_start_line;
    tok_start_column_next = tok_start_column;
    tok_len_next          = tok_len;
    res_count             = 2'd0;
    for (int i = 0; i < MAXRES; i++) begin
      res[i] = '0;
    end

    if (src_data.has_byte) begin
      unique case (scan_mode)
        M_IDLE: begin
          do_start = 1'b1;
        end
        M_IDENT: begin
          if (stok_pkg::is_alpha(b) || stok_pkg::is_digit(b)) begin
            tok_len_next    = stok_pkg::sat_inc(tok_len);
            cur_offset_next = cur_offset + 1'b1;
            cur_column_next = stok_pkg::sat_inc(cur_column);
          end else begin
            res[res_count] = stok_pkg::make_tok(stok_pkg::K_IDENT, tok_start_offset,
                                                tok_start_line, tok_start_column, tok_len,
                                                8'd0);
            res_count = res_count + 2'd1;
            do_start  = 1'b1;
          end
        end
        M_NUMBER: begin
          if (stok_pkg::is_digit(b) || b == stok_pkg::CH_DOT) begin
            tok_len_next    = stok_pkg::sat_inc(tok_len);
            cur_offset_next = cur_offset + 1'b1;
            cur_column_next = stok_pkg::sat_inc(cur_column);
          end else begin
            res[res_count] = stok_pkg::make_tok(stok_pkg::K_NUMBER, tok_start_offset,
                                                tok_start_line, tok_start_column, tok_len,
                                                8'd0);
            res_count = res_count + 2'd1;
            do_start  = 1'b1;
          end
        end
        M_STRING: begin
          // Any byte, newline included, extends the string.
          tok_len_next    = stok_pkg::sat_inc(tok_len);
          cur_offset_next = cur_offset + 1'b1;
          cur_column_next = stok_pkg::sat_inc(cur_column);
          if (b == stok_pkg::CH_QUOTE) begin
            res[res_count] = stok_pkg::make_tok(stok_pkg::K_STRING, tok_start_offset,
                                                tok_start_line, tok_start_column,
                                                tok_len_next, 8'd0);
            res_count      = res_count + 2'd1;
            scan_mode_next = M_IDLE;
          end
        end
        M_HELD: begin
          k = stok_pkg::pair_kind(held_byte, b);
          if (k != stok_pkg::K_NONE) begin
            tok_len_next    = stok_pkg::sat_inc(tok_len);
            cur_offset_next = cur_offset + 1'b1;
            cur_column_next = stok_pkg::sat_inc(cur_column);
            res[res_count]  = stok_pkg::make_tok(k, tok_start_offset, tok_start_line,
                                                 tok_start_column, tok_len_next, 8'd0);
            res_count       = res_count + 2'd1;
            scan_mode_next  = M_IDLE;
          end else begin
            res[res_count] = stok_pkg::make_tok(stok_pkg::held_single_kind(held_byte),
                                                tok_start_offset, tok_start_line,
                                                tok_start_column, tok_len, 8'd0);
            res_count = res_count + 2'd1;
            do_start  = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == stok_pkg::CH_SLASH) begin
            // Comment: column snaps back to where the first slash stood.
            cur_offset_next = cur_offset + 1'b1;
            cur_column_next = tok_start_column;
            scan_mode_next  = M_COMMENT;
          end else begin
            res[res_count] = stok_pkg::make_tok(stok_pkg::K_SLASH, tok_start_offset,
                                                tok_start_line, tok_start_column, tok_len,
                                                8'd0);
            res_count = res_count + 2'd1;
            do_start  = 1'b1;
          end
        end
        M_COMMENT: begin
          if (b == stok_pkg::CH_NL) begin
            do_start = 1'b1;
          end else begin
            cur_offset_next = cur_offset + 1'b1;
          end
        end
        default: begin
          // Error: bytes ignored until end of source.
        end
      endcase

      if (do_start) begin
        scan_mode_next = M_IDLE;
        k = stok_pkg::single_kind(b);
        if (b == stok_pkg::CH_SPACE || b == stok_pkg::CH_TAB) begin
          cur_offset_next = cur_offset_next + 1'b1;
          cur_column_next = stok_pkg::sat_inc(cur_column_next);
        end else if (b == stok_pkg::CH_NL) begin
          cur_offset_next = cur_offset_next + 1'b1;
          cur_line_next   = cur_line_next + 1'b1;
          cur_column_next = '0;
        end else if (b == stok_pkg::CH_CR) begin
          cur_offset_next = cur_offset_next + 1'b1;
        end else if (k != stok_pkg::K_NONE) begin
          res[res_count] = stok_pkg::make_tok(k, cur_offset_next, cur_line_next,
                                              cur_column_next, LB'(1), 8'd0);
          res_count       = res_count + 2'd1;
          cur_offset_next = cur_offset_next + 1'b1;
          cur_column_next = stok_pkg::sat_inc(cur_column_next);
        end else if (stok_pkg::is_held_op(b) || b == stok_pkg::CH_SLASH ||
                     stok_pkg::is_alpha(b) || stok_pkg::is_digit(b) ||
                     b == stok_pkg::CH_QUOTE) begin
          // Open a pending token at the current position.
          tok_start_offset_next = cur_offset_next;
          tok_start_line_next   = cur_line_next;
          tok_start_column_next = cur_column_next;
          tok_len_next          = LB'(1);
          cur_offset_next       = cur_offset_next + 1'b1;
          cur_column_next       = stok_pkg::sat_inc(cur_column_next);
          if (stok_pkg::is_held_op(b)) begin
            held_byte_next = b;
            scan_mode_next = M_HELD;
          end else if (b == stok_pkg::CH_SLASH) begin
            scan_mode_next = M_SLASH;
          end else if (stok_pkg::is_alpha(b)) begin
            scan_mode_next = M_IDENT;
          end else if (stok_pkg::is_digit(b)) begin
            scan_mode_next = M_NUMBER;
          end else begin
            scan_mode_next = M_STRING;
          end
        end else begin
          res[res_count] = stok_pkg::make_tok(stok_pkg::K_ERROR, cur_offset_next,
                                              cur_line_next, cur_column_next, LB'(1), b);
          res_count       = res_count + 2'd1;
          cur_offset_next = cur_offset_next + 1'b1;
          cur_column_next = stok_pkg::sat_inc(cur_column_next);
          scan_mode_next  = M_ERROR;
        end
      end

      if (scan_mode == M_HELD && scan_mode_next != M_HELD) begin
        held_byte_next = 8'd0;
      end
    end

    if (src_data.end_of_source) begin
      // Flush a pending token, then end-of-file at the current position.
      unique case (scan_mode_next)
        M_IDENT:  k = stok_pkg::K_IDENT;
        M_NUMBER: k = stok_pkg::K_NUMBER;
        M_STRING: k = stok_pkg::K_STRING;
        M_HELD:   k = stok_pkg::held_single_kind(held_byte_next);
        M_SLASH:  k = stok_pkg::K_SLASH;
        default:  k = stok_pkg::K_NONE;
      endcase
      if (k != stok_pkg::K_NONE) begin
        res[res_count] = stok_pkg::make_tok(k, tok_start_offset_next, tok_start_line_next,
                                            tok_start_column_next, tok_len_next, 8'd0);
        res_count = res_count + 2'd1;
      end
      res[res_count] = stok_pkg::make_tok(stok_pkg::K_EOF, cur_offset_next, cur_line_next,
                                          cur_column_next, '0, 8'd0);
      res_count = res_count + 2'd1;

      scan_mode_next        = M_IDLE;
      held_byte_next        = 8'd0;
      cur_offset_next       = '0;
      cur_line_next         = '0;
      cur_column_next       = '0;
      tok_start_offset_next = '0;
      tok_start_line_next   = '0;
      tok_start_column_next = '0;
      tok_len_next          = '0;
    end

    if (res_count != 2'd0) begin
      res[res_count - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode        <= M_IDLE;
      held_byte        <= 8'd0;
      cur_offset       <= '0;
      cur_line         <= '0;
      cur_column       <= '0;
      tok_start_offset <= '0;
      tok_start_line   <= '0;
      tok_start_column <= '0;
      tok_len          <= '0;
    end else if (src_fire) begin
      scan_mode        <= scan_mode_next;
      held_byte        <= held_byte_next;
      cur_offset       <= cur_offset_next;
      cur_line         <= cur_line_next;
      cur_column       <= cur_column_next;
      tok_start_offset <= tok_start_offset_next;
      tok_start_line   <= tok_start_line_next;
      tok_start_column <= tok_start_column_next;
      tok_len          <= tok_len_next;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (src_fire) begin
        wr_ptr <= wr_ptr + PTR_W'(res_count);
      end
      if (tok_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (src_fire ? CNT_W'(res_count) : '0) - CNT_W'(tok_fire);
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (src_fire) begin
      for (int i = 0; i < MAXRES; i++) begin
        if (2'(i) < res_count) begin
          queue[wr_ptr + PTR_W'(i)] <= res[i];
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QDEPTH), "token queue over capacity")
  `ASSERT_IMPLY(a_room_on_ready, src_ready, count <= CNT_W'(QDEPTH - MAXRES),
                "src_ready without room for a full burst")
  `ASSERT_NEXT(a_end_resets, src_fire && src_data.end_of_source,
               scan_mode == M_IDLE && cur_offset == '0 && cur_line == '0 && count != '0,
               "end of source did not reset scanner or queue eof")

endmodule

// ===== bench/tok_checker.sv =====
// Token stream checker: tracks the scanner state from accepted requests and compares tokens.
`timescale 1ns / 1ps

module tok_checker
  import stok_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  input  logic     src_ready,
  input  tok_in_t  src_data,
  input  logic     tok_valid,
  input  logic     tok_ready,
  input  tok_out_t tok_data,
  output int       fail_count,
  output int       outstanding
);

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING,
    SCAN_HELD, SCAN_SLASH, SCAN_COMMENT, SCAN_ERROR
  } scan_e;

  scan_e                  mode;
  logic [7:0]             held_op;
  logic [OFFSET_BITS-1:0] at_off, at_line, tok_off, tok_line;
  logic [LENGTH_BITS-1:0] at_col, tok_col, tok_len;

  logic [5:0] lone_kind [256];
  logic [5:0] held_kind [256];

  tok_out_t run_buf [3];
  int       run_len;
  tok_out_t expected_tokens [$];
  int       mismatches = 0;

  initial begin
    for (int i = 0; i < 256; i++) begin
      lone_kind[i] = K_NONE;
      held_kind[i] = K_BANG;
    end
    lone_kind[CH_CARET]  = K_CARET;
    lone_kind[CH_AMP]    = K_AMP;
    lone_kind[CH_STAR]   = K_STAR;
    lone_kind[CH_COLON]  = K_COLON;
    lone_kind[CH_SEMI]   = K_SEMI;
    lone_kind[CH_DOT]    = K_DOT;
    lone_kind[CH_COMMA]  = K_COMMA;
    lone_kind[CH_LPAREN] = K_LPAREN;
    lone_kind[CH_RPAREN] = K_RPAREN;
    lone_kind[CH_LBRACK] = K_LBRACK;
    lone_kind[CH_RBRACK] = K_RBRACK;
    lone_kind[CH_LBRACE] = K_LBRACE;
    lone_kind[CH_RBRACE] = K_RBRACE;
    held_kind[CH_PLUS]   = K_PLUS;
    held_kind[CH_MINUS]  = K_MINUS;
    held_kind[CH_EQUAL]  = K_ASSIGN;
    held_kind[CH_LT]     = K_LT;
    held_kind[CH_GT]     = K_GT;
  end

  function automatic logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic bit word_char(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
  endfunction

  function automatic bit decimal(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [5:0] joined_kind(input logic [7:0] h, input logic [7:0] b);
    case ({h, b})
      {CH_PLUS, CH_EQUAL}:  return K_PLUS_EQ;
      {CH_MINUS, CH_EQUAL}: return K_MINUS_EQ;
      {CH_EQUAL, CH_EQUAL}: return K_EQ;
      {CH_LT, CH_EQUAL}:    return K_LE;
      {CH_GT, CH_EQUAL}:    return K_GE;
      {CH_BANG, CH_EQUAL}:  return K_NE;
      {CH_PLUS, CH_PLUS}:   return K_INC;
      {CH_MINUS, CH_MINUS}: return K_DEC;
      default:              return K_NONE;
    endcase
  endfunction

  function void clear_scan();
    mode     = SCAN_IDLE;
    held_op  = '0;
    at_off   = '0;
    at_line  = '0;
    at_col   = '0;
    tok_off  = '0;
    tok_line = '0;
    tok_col  = '0;
    tok_len  = '0;
  endfunction

  function void queue_token(input logic [5:0] kind, input logic [OFFSET_BITS-1:0] off,
                            input logic [OFFSET_BITS-1:0] line,
                            input logic [LENGTH_BITS-1:0] col,
                            input logic [LENGTH_BITS-1:0] len, input logic [7:0] bad);
    if (run_len < 3) begin
      run_buf[run_len] = '{token_kind: kind, start_offset: off, start_line: line,
                           start_column: col, token_length: len, bad_byte: bad,
                           last_of_run: 1'b0};
      run_len++;
    end
  endfunction

  function void advance();
    at_off = at_off + 1'b1;
    at_col = bump(at_col);
  endfunction

  function void open_token(input scan_e m);
    tok_off  = at_off;
    tok_line = at_line;
    tok_col  = at_col;
    tok_len  = 1;
    mode     = m;
    advance();
  endfunction

  function void grow();
    tok_len = bump(tok_len);
    advance();
  endfunction

  function void close_pending(input logic [5:0] kind);
    queue_token(kind, tok_off, tok_line, tok_col, tok_len, 8'h00);
  endfunction

  // Byte seen with nothing pending.
  function void fresh_byte(input logic [7:0] b);
    mode = SCAN_IDLE;
    if (b == CH_SPACE || b == CH_TAB) begin
      advance();
    end else if (b == CH_NL) begin
      at_off  = at_off + 1'b1;
      at_line = at_line + 1'b1;
      at_col  = '0;
    end else if (b == CH_CR) begin
      at_off = at_off + 1'b1;
    end else if (lone_kind[b] != K_NONE) begin
      queue_token(lone_kind[b], at_off, at_line, at_col, 1, 8'h00);
      advance();
    end else if (b inside {CH_PLUS, CH_MINUS, CH_EQUAL, CH_LT, CH_GT, CH_BANG}) begin
      held_op = b;
      open_token(SCAN_HELD);
    end else if (b == CH_SLASH) begin
      open_token(SCAN_SLASH);
    end else if (word_char(b)) begin
      open_token(SCAN_IDENT);
    end else if (decimal(b)) begin
      open_token(SCAN_NUMBER);
    end else if (b == CH_QUOTE) begin
      open_token(SCAN_STRING);
    end else begin
      queue_token(K_ERROR, at_off, at_line, at_col, 1, b);
      advance();
      mode = SCAN_ERROR;
    end
  endfunction

  function void feed(input logic [7:0] b);
    logic [5:0] k;
    case (mode)
      SCAN_IDLE: fresh_byte(b);
      SCAN_IDENT: begin
        if (word_char(b) || decimal(b)) grow();
        else begin
          close_pending(K_IDENT);
          fresh_byte(b);
        end
      end
      SCAN_NUMBER: begin
        if (decimal(b) || b == CH_DOT) grow();
        else begin
          close_pending(K_NUMBER);
          fresh_byte(b);
        end
      end
      SCAN_STRING: begin
        grow();
        if (b == CH_QUOTE) begin
          close_pending(K_STRING);
          mode = SCAN_IDLE;
        end
      end
      SCAN_HELD: begin
        k = joined_kind(held_op, b);
        if (k != K_NONE) begin
          grow();
          close_pending(k);
          mode = SCAN_IDLE;
        end else begin
          close_pending(held_kind[held_op]);
          fresh_byte(b);
        end
        if (mode != SCAN_HELD) held_op = '0;
      end
      SCAN_SLASH: begin
        // second slash opens a comment; column snaps back to where it began
        if (b == CH_SLASH) begin
          at_off = at_off + 1'b1;
          at_col = tok_col;
          mode   = SCAN_COMMENT;
        end else begin
          close_pending(K_SLASH);
          fresh_byte(b);
        end
      end
      SCAN_COMMENT: begin
        if (b == CH_NL) fresh_byte(b);
        else at_off = at_off + 1'b1;
      end
      default: ;
    endcase
  endfunction

  function void flush_source();
    case (mode)
      SCAN_IDENT:  close_pending(K_IDENT);
      SCAN_NUMBER: close_pending(K_NUMBER);
      SCAN_STRING: close_pending(K_STRING);
      SCAN_HELD:   close_pending(held_kind[held_op]);
      SCAN_SLASH:  close_pending(K_SLASH);
      default: ;
    endcase
    queue_token(K_EOF, at_off, at_line, at_col, 0, 8'h00);
  endfunction

  function void predict_request(input tok_in_t req);
    run_len = 0;
    if (req.has_byte) feed(req.char_byte);
    if (req.end_of_source) begin
      flush_source();
      clear_scan();
    end
    if (run_len > 0) run_buf[run_len-1].last_of_run = 1'b1;
    for (int i = 0; i < run_len; i++) expected_tokens.push_back(run_buf[i]);
  endfunction

  function void check_token(input tok_out_t got);
    tok_out_t want;
    bit       bad;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("token with none expected: kind %0d off %0d line %0d col %0d len %0d",
                 got.token_kind, got.start_offset, got.start_line, got.start_column,
                 got.token_length);
      return;
    end
    want = expected_tokens.pop_front();
    bad = (got.token_kind   !== want.token_kind)   || (got.start_offset !== want.start_offset) ||
          (got.start_line   !== want.start_line)   || (got.start_column !== want.start_column) ||
          (got.token_length !== want.token_length) || (got.bad_byte     !== want.bad_byte)     ||
          (got.last_of_run  !== want.last_of_run);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("token mismatch at %0t", $realtime);
        $display("  exp kind %0d off %0d line %0d col %0d len %0d bad %02h last %0b",
                 want.token_kind, want.start_offset, want.start_line, want.start_column,
                 want.token_length, want.bad_byte, want.last_of_run);
        $display("  got kind %0d off %0d line %0d col %0d len %0d bad %02h last %0b",
                 got.token_kind, got.start_offset, got.start_line, got.start_column,
                 got.token_length, got.bad_byte, got.last_of_run);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
    end else begin
      if (src_valid && src_ready) predict_request(src_data);
      if (tok_valid && tok_ready) check_token(tok_data);
    end
    fail_count  <= mismatches;
    outstanding <= expected_tokens.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top: drives source text into the tokenizer and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import stok_pkg::*;

  localparam int LIMIT      = 20_000;     // cycles; a few hundred requests need far fewer
  localparam int STALL_AT   = 120;        // cycle where the token side holds off
  localparam int STALL_LEN  = 60;
  localparam int NUM_OPS    = 28;
  localparam int RAND_BYTES = 230;

  logic     clk;
  logic     rst       = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_ready;
  tok_in_t  src_data  = '0;
  logic     tok_valid;
  logic     tok_ready = 1'b0;
  tok_out_t tok_data;

  int cycle = 0;
  int fail_count;
  int outstanding;
  int byte_count = 0;   // requests that carried a byte
  int op_turn = 0;      // rotates through every operator spelling
  logic [8:0] src_text [$];  // {bare, byte} entries of the source being built

  string op_text [NUM_OPS] = '{"^", "&", "*", "+", "++", "+=", "-", "--", "-=", "=", "==",
                               ":", ";", ".", ",", "/", "(", ")", "[", "]", "{", "}",
                               "<", "<=", ">", ">=", "!", "!="};

  // window where neither side idles
  wire calm = (cycle >= 250) && (cycle < 400);

  source_tokenizer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data)
  );

  tok_checker token_check (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .src_data    (src_data),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .tok_data    (tok_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    if (cycle >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Token side: random back-pressure, one long hold-off so the output
  // queue fills and src_ready drops while requests keep coming.
  initial begin
    forever begin
      @(posedge clk);
      if (cycle == STALL_AT) begin
        tok_ready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
      end else begin
        tok_ready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  // One request: optional idle gap first, then hold valid until taken.
  // Valid is only lowered when a gap follows, so it never toggles in one step.
  task automatic offer(input logic [7:0] b, input logic has, input logic eos);
    if (!calm && $urandom_range(99) < 15) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= '{char_byte: b, has_byte: has, end_of_source: eos};
    do @(posedge clk); while (!src_ready);
    if (has) byte_count++;
  endtask

  task automatic put(input logic [7:0] b, input bit eos = 1'b0);
    offer(b, 1'b1, eos);
  endtask

  task automatic send_text(input string s, input bit eos = 1'b0);
    for (int i = 0; i < s.len(); i++) put(s[i], eos && (i == s.len() - 1));
  endtask

  // --- random source builders ---------------------------------------------

  function automatic void add(input logic [7:0] b);
    src_text.push_back({1'b0, b});
  endfunction

  function automatic logic [7:0] any_word_char(input bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'h61 + r;
    if (r < 52) return 8'h41 + (r - 26);
    if (r == 52) return CH_UNDER;
    return 8'h30 + (r - 53);
  endfunction

  function automatic void add_word();
    add(any_word_char(1'b1));
    repeat ($urandom_range(4)) add(any_word_char(1'b0));
  endfunction

  function automatic void add_number();
    add(8'h30 + $urandom_range(9));
    repeat ($urandom_range(4))
      add(($urandom_range(3) == 0) ? CH_DOT : 8'h30 + $urandom_range(9));
  endfunction

  // Strings sometimes hold a newline and sometimes never close.
  function automatic void add_string();
    logic [7:0] c;
    add(CH_QUOTE);
    repeat ($urandom_range(4)) begin
      c = $urandom_range(8'h7E, 8'h20);
      if (c == CH_QUOTE || $urandom_range(9) == 0) c = CH_NL;
      add(c);
    end
    if ($urandom_range(99) < 85) add(CH_QUOTE);
  endfunction

  function automatic void add_operator();
    string s;
    s = op_text[op_turn % NUM_OPS];
    op_turn++;
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endfunction

  function automatic void add_blank();
    case ($urandom_range(3))
      0: add(CH_SPACE);
      1: add(CH_TAB);
      2: add(CH_CR);
      default: add(CH_NL);
    endcase
  endfunction

  function automatic void add_comment();
    add(CH_SLASH);
    add(CH_SLASH);
    repeat ($urandom_range(5)) add($urandom_range(8'h7E, 8'h20));
    if ($urandom_range(9) != 0) add(CH_NL);
  endfunction

  // Bytes no token can start with: high half, controls, stray punctuation.
  function automatic void add_junk();
    case ($urandom_range(2))
      0: add($urandom_range(255, 128));
      1: add($urandom_range(8));
      default: add(8'h40 + $urandom_range(0) * 0);  // '@'
    endcase
  endfunction

  task automatic random_source();
    int  n_tok;
    int  pick;
    bit  end_on_byte;
    src_text.delete();
    n_tok = $urandom_range(20, 2);
    repeat (n_tok) begin
      pick = $urandom_range(99);
      if (pick < 22)      add_word();
      else if (pick < 36) add_number();
      else if (pick < 44) add_string();
      else if (pick < 72) add_operator();
      else if (pick < 82) add_blank();
      else if (pick < 88) add_comment();
      else if (pick < 90) add_junk();
      else if (pick < 95) src_text.push_back({1'b1, 8'($urandom_range(255))});
      if ($urandom_range(99) < 55) add(CH_SPACE);
    end
    end_on_byte = (src_text.size() != 0) && $urandom_range(1);
    for (int i = 0; i < src_text.size(); i++)
      offer(src_text[i][7:0], !src_text[i][8], end_on_byte && (i == src_text.size() - 1));
    if (!end_on_byte) offer(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // --- main sequence --------------------------------------------------------

  initial begin
    int base;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identifier with digit and underscore, tab, number with dots, carriage return
    send_text("x9_");
    put(CH_TAB);
    send_text("1.2.");
    put(CH_CR);
    // string with a newline inside, never closed: flushed by the end marker
    send_text("\"a");
    put(CH_NL);
    send_text("b");
    offer(8'hA5, 1'b0, 1'b0);   // bare request, no end: nothing comes out
    offer(8'h5A, 1'b0, 1'b1);   // bare end marker

    // leading dot is an operator, comment to newline, slash pending at the end
    send_text(".5 // c");
    put(CH_NL);
    put(CH_SLASH, 1'b1);

    // comment running to the end of the source
    send_text("a//z", 1'b1);

    // unknown bytes at both extremes, everything after is ignored
    put(8'h00);
    put(8'hFF);
    put("a", 1'b1);

    // random sources until the byte budget is spent and every operator was seen
    base = byte_count;
    while (byte_count - base < RAND_BYTES || op_turn < NUM_OPS) random_source();

    // held operator flushed by the end marker
    put(CH_SPACE);
    put(CH_PLUS, 1'b1);

    src_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
